FILE: sv/vfo_tuning_synth_divider_assert.svh
// ----------------------------------------------------------------------------
// vfo_tuning_synth_divider_assert.svh
// Assertion macros shared by the tuning controller RTL.
// ----------------------------------------------------------------------------
`ifndef VFO_TUNING_SYNTH_DIVIDER_ASSERT_SVH
`define VFO_TUNING_SYNTH_DIVIDER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define VTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset.
`define VTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/vts_pkg.sv
// ----------------------------------------------------------------------------
// vts_pkg
// Widths, constants, codes and step tables of the tuning controller.
// ----------------------------------------------------------------------------
package vts_pkg;

    localparam int FREQ_W   = 28;
    localparam int CAL_W    = 17;
    localparam int STEP_W   = 14;
    localparam int RSTEP_W  = 16;
    localparam int CMD_W    = 3;
    localparam int DIV_W    = 10;
    localparam int INT_W    = 6;
    localparam int NUM_W    = 20;
    localparam int REM_W    = 30;
    localparam int SUB_W    = FREQ_W + DIV_W;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 112;

    localparam logic [REM_W-1:0]  VCO_TARGET = 30'd900000000;
    localparam logic [REM_W-1:0]  REF_FREQ   = 30'd25000000;
    localparam logic [REM_W-1:0]  REF_MHZ    = 30'd25;
    localparam logic [DIV_W-1:0]  DIV_MAX    = '1;
    localparam logic [FREQ_W-1:0] FREQ_MAX   = '1;

    localparam logic [FREQ_W-1:0] SAVED0_RST = 28'd7100000;
    localparam logic [FREQ_W-1:0] SAVED1_RST = 28'd14100000;
    localparam logic [FREQ_W-1:0] B0_LO_RST  = 28'd7000000;
    localparam logic [FREQ_W-1:0] B0_HI_RST  = 28'd7200000;
    localparam logic [CAL_W-1:0]  B0_CAL_RST = 17'd239;
    localparam logic [FREQ_W-1:0] B1_LO_RST  = 28'd14000000;
    localparam logic [FREQ_W-1:0] B1_HI_RST  = 28'd14350000;
    localparam logic [CAL_W-1:0]  B1_CAL_RST = 17'd490;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_B0_LO  = 3'd0;
    localparam logic [2:0] REG_B0_HI  = 3'd1;
    localparam logic [2:0] REG_B0_CAL = 3'd2;
    localparam logic [2:0] REG_B1_LO  = 3'd3;
    localparam logic [2:0] REG_B1_HI  = 3'd4;
    localparam logic [2:0] REG_B1_CAL = 3'd5;

    // Event commands
    localparam logic [CMD_W-1:0] CMD_DOWN    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UP      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STEP    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BAND    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESTORE = 3'd4;

    // Step codes
    localparam logic [1:0] STEP_10K  = 2'd0;
    localparam logic [1:0] STEP_1K   = 2'd1;
    localparam logic [1:0] STEP_500  = 2'd2;
    localparam logic [1:0] STEP_100  = 2'd3;

    typedef logic [FREQ_W-1:0] t_freq;

    function automatic logic [STEP_W-1:0] step_hz(input logic [1:0] code);
        logic [STEP_W-1:0] hz;
        case (code)
            STEP_10K: hz = 14'd10000;
            STEP_1K:  hz = 14'd1000;
            STEP_500: hz = 14'd500;
            default:  hz = 14'd100;
        endcase
        return hz;
    endfunction

    // Anything that is not one of the four steps falls back to 1 kHz
    function automatic logic [1:0] step_code_of(input logic [RSTEP_W-1:0] hz);
        logic [1:0] code;
        case (hz)
            16'd10000: code = STEP_10K;
            16'd1000:  code = STEP_1K;
            16'd500:   code = STEP_500;
            16'd100:   code = STEP_100;
            default:   code = STEP_1K;
        endcase
        return code;
    endfunction

endpackage

FILE: sv/vts_sub_cmp.sv
// ----------------------------------------------------------------------------
// vts_sub_cmp
// Shared restoring-division step: compare remainder against a shifted
// divisor and give the reduced remainder.
// ----------------------------------------------------------------------------
module vts_sub_cmp (
    input  logic [vts_pkg::REM_W-1:0] i_rem,
    input  logic [vts_pkg::SUB_W-1:0] i_sub,
    output logic                      o_ge,
    output logic [vts_pkg::REM_W-1:0] o_diff
);
    import vts_pkg::*;

    logic [SUB_W:0] diff;

    assign diff   = {{(SUB_W - REM_W + 1){1'b0}}, i_rem} - {1'b0, i_sub};
    // No borrow means the divisor fits
    assign o_ge   = ~diff[SUB_W];
    assign o_diff = diff[REM_W-1:0];

endmodule

FILE: sv/vfo_tuning_synth_divider.sv
// ----------------------------------------------------------------------------
// vfo_tuning_synth_divider
// Sequence: an accepted event steps through sum, 11 divider steps, multiply,
//   6 integer steps, 20 numerator steps and output load; the divider, integer
//   and numerator steps share the subtract-compare unit. A saturating divider
//   ends the divider steps after the first, a zero output frequency skips them,
//   and a stalled result holds the output load. s_axis_tready is high only when idle.
// Reset: synchronous, active low; band limits, calibration, tuned state and
//   saved band frequencies load their defaults at once, no clearing pass.
// ----------------------------------------------------------------------------
module vfo_tuning_synth_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input item stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: restore_freq[27:0], restore_step[43:28], zero fill
    input  logic [vts_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: command[2:0]
    input  logic [vts_pkg::CMD_W-1:0]      s_axis_tuser,
    // result item stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: tuned_freq[27:0], step_hz[41:28], out_freq[69:42],
    //        ms_divider[79:70], pll_integer[85:80], pll_numerator[105:86], zero fill
    output logic [vts_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // tuser: band[0]
    output logic [0:0]                     m_axis_tuser,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vts_pkg::ADDR_W-1:0]     paddr,
    input  logic [vts_pkg::DATA_W-1:0]     pwdata,
    output logic [vts_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);
    import vts_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_INT  = 3'd4;
    localparam logic [2:0] S_FRAC = 3'd5;
    localparam logic [2:0] S_PUSH = 3'd6;

    localparam logic [4:0] DIV_TOP  = 5'd10;
    localparam logic [4:0] INT_TOP  = 5'd5;
    localparam logic [4:0] FRAC_TOP = 5'd19;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    t_freq            r_b0_lo, r_b0_hi, r_b1_lo, r_b1_hi;
    logic [CAL_W-1:0] r_b0_cal, r_b1_cal;
    logic             cfg_wr;
    logic [2:0]       cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[4:2];

    always_comb begin
        case (cfg_idx)
            REG_B0_LO:  prdata = {{(DATA_W - FREQ_W){1'b0}}, r_b0_lo};
            REG_B0_HI:  prdata = {{(DATA_W - FREQ_W){1'b0}}, r_b0_hi};
            REG_B0_CAL: prdata = {{(DATA_W - CAL_W){1'b0}}, r_b0_cal};
            REG_B1_LO:  prdata = {{(DATA_W - FREQ_W){1'b0}}, r_b1_lo};
            REG_B1_HI:  prdata = {{(DATA_W - FREQ_W){1'b0}}, r_b1_hi};
            REG_B1_CAL: prdata = {{(DATA_W - CAL_W){1'b0}}, r_b1_cal};
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Tuning state and sequencer registers
    // ------------------------------------------------------------------
    logic [2:0]        r_state, n_state;
    t_freq             r_walk, n_walk;
    logic [1:0]        r_step_code, n_step_code;
    logic              r_band, n_band;
    t_freq             r_saved0, n_saved0, r_saved1, n_saved1;

    t_freq             r_ofreq;
    logic [REM_W-1:0]  r_rem;
    logic [SUB_W-1:0]  r_sub;
    logic [4:0]        r_k;
    logic [NUM_W-1:0]  r_q;
    logic [DIV_W-1:0]  r_div;
    logic [INT_W-1:0]  r_int;

    logic              r_m_valid;
    t_freq             r_m_tuned, r_m_ofreq;
    logic [STEP_W-1:0] r_m_step;
    logic              r_m_band;
    logic [DIV_W-1:0]  r_m_div;
    logic [INT_W-1:0]  r_m_int;
    logic [NUM_W-1:0]  r_m_num;

    logic              in_acc;
    logic              push;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign push          = (r_state == S_PUSH) & (~r_m_valid | m_axis_tready);

    // ------------------------------------------------------------------
    // Event update: applied in the accept cycle
    // ------------------------------------------------------------------
    t_freq             lo, hi, dn, base, rf;
    logic [STEP_W-1:0] step;
    logic [FREQ_W:0]   up_sum;
    logic [CMD_W-1:0]  cmd;

    assign cmd = s_axis_tuser;

    always_comb begin
        lo   = r_band ? r_b1_lo : r_b0_lo;
        hi   = r_band ? r_b1_hi : r_b0_hi;
        step = step_hz(r_step_code);

        // down: drop by the step floored at zero, then clamp low then high
        dn = (r_walk >= {{(FREQ_W - STEP_W){1'b0}}, step}) ?
             r_walk - {{(FREQ_W - STEP_W){1'b0}}, step} : '0;
        if (dn < lo) dn = lo;
        if (dn > hi) dn = hi;

        // up: lift to the low limit first, then add, then cap at high
        base   = (r_walk < lo) ? lo : r_walk;
        up_sum = {1'b0, base} + {{(FREQ_W - STEP_W + 1){1'b0}}, step};

        rf = s_axis_tdata[FREQ_W-1:0];
        if (rf < lo) rf = lo;
        if (rf > hi) rf = hi;

        n_walk      = r_walk;
        n_step_code = r_step_code;
        n_band      = r_band;
        n_saved0    = r_saved0;
        n_saved1    = r_saved1;
        case (cmd)
            CMD_DOWN: n_walk = dn;
            CMD_UP: begin
                n_walk = (up_sum > {1'b0, hi}) ? hi : up_sum[FREQ_W-1:0];
            end
            CMD_STEP: n_step_code = r_step_code + 2'd1;
            CMD_BAND: begin
                // save this band, switch, recall the other
                if (r_band) begin
                    n_saved1 = r_walk;
                    n_walk   = r_saved0;
                end else begin
                    n_saved0 = r_walk;
                    n_walk   = r_saved1;
                end
                n_band = ~r_band;
            end
            CMD_RESTORE: begin
                n_walk      = rf;
                n_step_code = step_code_of(s_axis_tdata[FREQ_W+RSTEP_W-1:FREQ_W]);
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output frequency with saturation
    // ------------------------------------------------------------------
    logic [CAL_W-1:0]  cal;
    logic [FREQ_W:0]   cal_sum;
    t_freq             ofreq;

    assign cal     = r_band ? r_b1_cal : r_b0_cal;
    assign cal_sum = {1'b0, r_walk} + {{(FREQ_W - CAL_W + 1){1'b0}}, cal};
    assign ofreq   = cal_sum[FREQ_W] ? FREQ_MAX : cal_sum[FREQ_W-1:0];

    // ------------------------------------------------------------------
    // Shared subtract-compare unit and the multiplier
    // ------------------------------------------------------------------
    logic              ge;
    logic [REM_W-1:0]  diff;
    logic [SUB_W-1:0]  prod;

    vts_sub_cmp u_sub_cmp (
        .i_rem  (r_rem),
        .i_sub  (r_sub),
        .o_ge   (ge),
        .o_diff (diff)
    );

    assign prod = {{FREQ_W{1'b0}}, r_div} * {{DIV_W{1'b0}}, r_ofreq};

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc) n_state = S_SUM;
            S_SUM:  n_state = (ofreq == '0) ? S_MUL : S_DIV;
            S_DIV: begin
                // a hit on the first step means a quotient beyond 1023
                if ((r_k == DIV_TOP && ge) || r_k == '0) n_state = S_MUL;
            end
            S_MUL:  n_state = S_INT;
            S_INT:  if (r_k == '0) n_state = S_FRAC;
            S_FRAC: if (r_k == '0) n_state = S_PUSH;
            S_PUSH: if (push) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control and tuning state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_m_valid   <= 1'b0;
            r_walk      <= SAVED0_RST;
            r_step_code <= STEP_1K;
            r_band      <= 1'b0;
            r_saved0    <= SAVED0_RST;
            r_saved1    <= SAVED1_RST;
            r_b0_lo     <= B0_LO_RST;
            r_b0_hi     <= B0_HI_RST;
            r_b0_cal    <= B0_CAL_RST;
            r_b1_lo     <= B1_LO_RST;
            r_b1_hi     <= B1_HI_RST;
            r_b1_cal    <= B1_CAL_RST;
        end else begin
            r_state <= n_state;
            if (push) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (in_acc) begin
                r_walk      <= n_walk;
                r_step_code <= n_step_code;
                r_band      <= n_band;
                r_saved0    <= n_saved0;
                r_saved1    <= n_saved1;
            end
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_B0_LO:  r_b0_lo  <= pwdata[FREQ_W-1:0];
                    REG_B0_HI:  r_b0_hi  <= pwdata[FREQ_W-1:0];
                    REG_B0_CAL: r_b0_cal <= pwdata[CAL_W-1:0];
                    REG_B1_LO:  r_b1_lo  <= pwdata[FREQ_W-1:0];
                    REG_B1_HI:  r_b1_hi  <= pwdata[FREQ_W-1:0];
                    REG_B1_CAL: r_b1_cal <= pwdata[CAL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath: divider, integer and numerator steps share one unit
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_SUM: begin
                r_ofreq <= ofreq;
                r_rem   <= VCO_TARGET;
                r_sub   <= {ofreq, {DIV_W{1'b0}}};
                r_k     <= DIV_TOP;
                r_q     <= '0;
                // zero output frequency: divider and PLL words are all zero
                r_div   <= '0;
            end
            S_DIV: begin
                if (r_k == DIV_TOP) begin
                    if (ge) r_div <= DIV_MAX;
                end else begin
                    if (ge) r_rem <= diff;
                    r_q <= {r_q[NUM_W-2:0], ge};
                    if (r_k == '0) r_div <= {r_q[DIV_W-2:0], ge};
                end
                r_sub <= r_sub >> 1;
                r_k   <= r_k - 5'd1;
            end
            S_MUL: begin
                // pll never exceeds 900 MHz, so the low bits hold it all
                r_rem <= prod[REM_W-1:0];
                r_sub <= {{(SUB_W - REM_W){1'b0}}, REF_FREQ << INT_TOP};
                r_k   <= INT_TOP;
                r_q   <= '0;
            end
            S_INT: begin
                if (ge) r_rem <= diff;
                if (r_k == '0) begin
                    r_int <= {r_q[INT_W-2:0], ge};
                    r_sub <= {{(SUB_W - REM_W){1'b0}}, REF_MHZ << FRAC_TOP};
                    r_k   <= FRAC_TOP;
                    r_q   <= '0;
                end else begin
                    r_q   <= {r_q[NUM_W-2:0], ge};
                    r_sub <= r_sub >> 1;
                    r_k   <= r_k - 5'd1;
                end
            end
            S_FRAC: begin
                // residual below 25 MHz, divided by 25 gives the numerator
                if (ge) r_rem <= diff;
                r_q   <= {r_q[NUM_W-2:0], ge};
                r_sub <= r_sub >> 1;
                if (r_k != '0) r_k <= r_k - 5'd1;
            end
            default: ;
        endcase
    end

    // Output register: holds the result item until taken
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_m_tuned <= r_walk;
            r_m_step  <= step_hz(r_step_code);
            r_m_band  <= r_band;
            r_m_ofreq <= r_ofreq;
            r_m_div   <= r_div;
            r_m_int   <= r_int;
            r_m_num   <= r_q;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_band;
    assign m_axis_tdata  = {{(M_TDATA_W - 2*FREQ_W - STEP_W - DIV_W - INT_W - NUM_W){1'b0}},
                            r_m_num, r_m_int, r_m_div, r_m_ofreq, r_m_step, r_m_tuned};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "vfo_tuning_synth_divider_assert.svh"

    `VTS_ASSERT_NEXT(a_acc_to_sum, in_acc, r_state == S_SUM, "accepted item did not start")
    `VTS_ASSERT_NEXT(a_push_valid, push, m_axis_tvalid && r_state == S_IDLE, "result not loaded")
    `VTS_ASSERT_NOW(a_frac_rem, r_state == S_FRAC, r_rem < REF_FREQ, "residual not below ref")
    `VTS_ASSERT_NOW(a_pll_range, r_state == S_INT && r_k == INT_TOP, r_rem <= VCO_TARGET, "pll over range")
    `VTS_ASSERT_NOW(a_div_k, r_state == S_DIV, r_k <= DIV_TOP, "divider step count out of range")

endmodule
